@@ sv/cpfb_pkg.sv @@
`timescale 1ns / 1ps
package cpfb_pkg;

  localparam int CONTIGS_DEFAULT = 1024;
  localparam int CONTIG_W = 10;
  localparam int POS_W = 32;
  localparam int MAPQ_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [POS_W-1:0] PULLBACK = 32'd100;

  localparam logic [CFG_IDX_W-1:0] REG_MAPQ = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN = 1'd1;

  localparam logic [MAPQ_W-1:0] MAPQ_RESET = 8'd1;
  localparam logic [POS_W-1:0] BIN_RESET = 32'd1000;

  localparam int IN_DATA_W = 152;
  localparam int OUT_DATA_W = 80;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RECORD = 1'b1;

  // A record that survived the checks, on its way into the divider.
  typedef struct packed {
    logic valid;
    logic [CONTIG_W-1:0] contig;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
  } rec_t;

  // A finished bin pair, before it is split into two transactions.
  typedef struct packed {
    logic valid;
    logic [CONTIG_W-1:0] contig;
    logic [POS_W-1:0] bin_a;
    logic [POS_W-1:0] bin_b;
  } pair_t;

  // One restoring division step: bit 32 is the quotient bit, the rest the new remainder.
  function automatic logic [POS_W:0] div_step(logic [POS_W-1:0] rem, logic nb,
                                               logic [POS_W-1:0] d);
    logic [POS_W:0] t;
    logic [POS_W:0] diff;
    t = {rem, nb};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, diff[POS_W-1:0]};
    end else begin
      div_step = {1'b0, t[POS_W-1:0]};
    end
  endfunction

endpackage

@@ sv/contact_pair_filter_binner.sv @@
`timescale 1ns / 1ps
// Contact pair filter and binner.
// Input stream: tuser selects the transaction kind (0 loads a contig length, 1 is a
// contact record); tdata carries both read ends and the load entry. Loads write the
// length table and produce nothing. A kept record on one contig produces two output
// transactions, (row, col) and then the mirrored pair with tlast high.
// Configuration: cfg_index 0 is the mapping quality threshold, 1 the bin size; write
// only while the block is idle. cfg_ready is always high.
// Pipeline from input acceptance to the first output transaction: a table read, a
// check stage, 32 restoring-division stages (one quotient bit each) and the output
// register. One record can enter every cycle while the output is empty; a kept record
// holds the output and stalls the pipeline until both of its transactions are taken.
// Any output stall freezes the whole pipeline; s_axis_tready drops with it and nothing
// is lost or repeated. Reset clears all valid state and loads the register defaults;
// the length table is not cleared and must be loaded before records use it.
module contact_pair_filter_binner #(
  parameter int MAX_CONTIGS = cpfb_pkg::CONTIGS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // contig_a, known_a, pos_a, mapq_a, b_given, contig_b, known_b, pos_b, mapq_b,
  // table_index, table_length, zero fill
  input  logic [cpfb_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // func
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // contig, row_bin, col_bin, zero fill
  output logic [cpfb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic m_axis_tlast,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [cpfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpfb_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic en;
  logic [cpfb_pkg::MAPQ_W-1:0] mapq_threshold;
  logic [cpfb_pkg::POS_W-1:0] bin_size;
  cpfb_pkg::rec_t rec;
  cpfb_pkg::pair_t pair;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapq_threshold <= cpfb_pkg::MAPQ_RESET;
      bin_size <= cpfb_pkg::BIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cpfb_pkg::REG_MAPQ: mapq_threshold <= cfg_data[cpfb_pkg::MAPQ_W-1:0];
        cpfb_pkg::REG_BIN:  bin_size <= cfg_data;
        default: ;
      endcase
    end
  end

  cpfb_front #(.MAX_CONTIGS(MAX_CONTIGS)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_axis_tvalid),
    .func(s_axis_tuser),
    .contig_a(s_axis_tdata[9:0]), .known_a(s_axis_tdata[10]),
    .pos_a(s_axis_tdata[42:11]), .mapq_a(s_axis_tdata[50:43]),
    .b_given(s_axis_tdata[51]), .contig_b(s_axis_tdata[61:52]),
    .known_b(s_axis_tdata[62]), .pos_b(s_axis_tdata[94:63]),
    .mapq_b(s_axis_tdata[102:95]), .table_index(s_axis_tdata[112:103]),
    .table_length(s_axis_tdata[144:113]),
    .mapq_threshold(mapq_threshold), .rec(rec)
  );

  cpfb_div u_div (
    .clk(clk), .rst(rst), .en(en), .bin_size(bin_size), .rec(rec), .pair(pair)
  );

  cpfb_out u_out (
    .clk(clk), .rst(rst), .pair(pair), .en(en), .tready(m_axis_tready),
    .tvalid(m_axis_tvalid), .tlast(m_axis_tlast), .tdata(m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_no_input_mid_pair: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input accepted while a pair is half sent");

  a_mirror_follows: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("first result not followed by its mirror");

  a_mirror_bins: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tdata[41:10] == $past(m_axis_tdata[73:42]) &&
      m_axis_tdata[9:0] == $past(m_axis_tdata[9:0]))
    else $error("mirrored result does not swap the bins");
`endif

endmodule

@@ sv/cpfb_front.sv @@
`timescale 1ns / 1ps
module cpfb_front #(
  parameter int MAX_CONTIGS = cpfb_pkg::CONTIGS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic func,
  input  logic [cpfb_pkg::CONTIG_W-1:0] contig_a,
  input  logic known_a,
  input  logic [cpfb_pkg::POS_W-1:0] pos_a,
  input  logic [cpfb_pkg::MAPQ_W-1:0] mapq_a,
  input  logic b_given,
  input  logic [cpfb_pkg::CONTIG_W-1:0] contig_b,
  input  logic known_b,
  input  logic [cpfb_pkg::POS_W-1:0] pos_b,
  input  logic [cpfb_pkg::MAPQ_W-1:0] mapq_b,
  input  logic [cpfb_pkg::CONTIG_W-1:0] table_index,
  input  logic [cpfb_pkg::POS_W-1:0] table_length,
  input  logic [cpfb_pkg::MAPQ_W-1:0] mapq_threshold,
  output cpfb_pkg::rec_t rec
);

  localparam int AW = (MAX_CONTIGS > 1) ? $clog2(MAX_CONTIGS) : 1;

  logic [cpfb_pkg::POS_W-1:0] len_mem [0:MAX_CONTIGS-1];

  logic [cpfb_pkg::CONTIG_W-1:0] cb;
  logic kb;
  logic pre_ok;
  logic idx_ok;

  logic valid1;
  logic ok1;
  logic [cpfb_pkg::CONTIG_W-1:0] contig1;
  logic [cpfb_pkg::POS_W-1:0] pa1;
  logic [cpfb_pkg::POS_W-1:0] pb1;
  logic [cpfb_pkg::POS_W-1:0] len1;

  logic fa_ok, fb_ok;
  logic [cpfb_pkg::POS_W-1:0] fa, fb;
  logic [cpfb_pkg::POS_W-1:0] pa_back, pb_back;

  always_comb begin
    cb = b_given ? contig_b : contig_a;
    kb = b_given ? known_b : known_a;
    idx_ok = int'(table_index) < MAX_CONTIGS;
    // Pairs on different contigs give nothing, so one table read per record is enough.
    pre_ok = (func == cpfb_pkg::FUNC_RECORD) && known_a && kb &&
             (int'(contig_a) < MAX_CONTIGS) && (contig_a == cb) &&
             (mapq_a >= mapq_threshold) && (mapq_b >= mapq_threshold);
  end

  always_ff @(posedge clk) begin
    if (en && in_valid && func == cpfb_pkg::FUNC_LOAD && idx_ok) begin
      len_mem[AW'(table_index)] <= table_length;
    end
    if (en) begin
      len1 <= len_mem[AW'(contig_a)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (en) begin
      valid1 <= in_valid;
    end
    if (en) begin
      ok1 <= pre_ok;
      contig1 <= contig_a;
      pa1 <= pos_a;
      pb1 <= pos_b;
    end
  end

  always_comb begin
    pa_back = pa1 - cpfb_pkg::PULLBACK;
    pb_back = pb1 - cpfb_pkg::PULLBACK;
    fa_ok = (pa1 < len1) || ((pa1 >= cpfb_pkg::PULLBACK) && (pa_back < len1));
    fb_ok = (pb1 < len1) || ((pb1 >= cpfb_pkg::PULLBACK) && (pb_back < len1));
    fa = (pa1 < len1) ? pa1 : pa_back;
    fb = (pb1 < len1) ? pb1 : pb_back;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.valid <= 1'b0;
    end else if (en) begin
      rec.valid <= valid1 && ok1 && fa_ok && fb_ok;
    end
    if (en) begin
      rec.contig <= contig1;
      rec.pos_a <= fa;
      rec.pos_b <= fb;
    end
  end

endmodule

@@ sv/cpfb_div.sv @@
`timescale 1ns / 1ps
module cpfb_div (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic [cpfb_pkg::POS_W-1:0] bin_size,
  input  cpfb_pkg::rec_t rec,
  output cpfb_pkg::pair_t pair
);

  localparam int N = cpfb_pkg::POS_W;

  logic v [0:N];
  logic [cpfb_pkg::CONTIG_W-1:0] ctg [0:N];
  logic [N-1:0] rem_a [0:N];
  logic [N-1:0] rem_b [0:N];
  logic [N-1:0] nq_a [0:N];
  logic [N-1:0] nq_b [0:N];

  assign v[0] = rec.valid;
  assign ctg[0] = rec.contig;
  assign rem_a[0] = '0;
  assign rem_b[0] = '0;
  assign nq_a[0] = rec.pos_a;
  assign nq_b[0] = rec.pos_b;

  // One quotient bit per stage for each end; the dividend shifts out as the quotient shifts in.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N:0] sa, sb;
    assign sa = cpfb_pkg::div_step(rem_a[k], nq_a[k][N-1], bin_size);
    assign sb = cpfb_pkg::div_step(rem_b[k], nq_b[k][N-1], bin_size);
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
      if (en) begin
        ctg[k+1] <= ctg[k];
        rem_a[k+1] <= sa[N-1:0];
        rem_b[k+1] <= sb[N-1:0];
        nq_a[k+1] <= {nq_a[k][N-2:0], sa[N]};
        nq_b[k+1] <= {nq_b[k][N-2:0], sb[N]};
      end
    end
  end

  always_comb begin
    pair.valid = v[N];
    pair.contig = ctg[N];
    pair.bin_a = (bin_size == '0) ? '0 : nq_a[N];
    pair.bin_b = (bin_size == '0) ? '0 : nq_b[N];
  end

endmodule

@@ sv/cpfb_out.sv @@
`timescale 1ns / 1ps
module cpfb_out (
  input  logic clk,
  input  logic rst,
  input  cpfb_pkg::pair_t pair,
  output logic en,
  input  logic tready,
  output logic tvalid,
  output logic tlast,
  output logic [cpfb_pkg::OUT_DATA_W-1:0] tdata
);

  logic busy;
  logic phase;
  logic [cpfb_pkg::CONTIG_W-1:0] contig;
  logic [cpfb_pkg::POS_W-1:0] bin_a, bin_b;
  logic [cpfb_pkg::POS_W-1:0] row, col;

  // The pipeline moves while the output is empty, or once the mirrored transaction goes out.
  assign en = !busy || (phase && tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= 1'b0;
    end else if (en) begin
      busy <= pair.valid;
      phase <= 1'b0;
    end else if (tready) begin
      phase <= 1'b1;
    end
    if (en) begin
      contig <= pair.contig;
      bin_a <= pair.bin_a;
      bin_b <= pair.bin_b;
    end
  end

  always_comb begin
    row = phase ? bin_b : bin_a;
    col = phase ? bin_a : bin_b;
    tvalid = busy;
    tlast = phase;
    tdata = {6'd0, col, row, contig};
  end

endmodule
